@@ design/qwf_pkg.sv @@
package qwf_pkg;

  localparam int HISTORY_DEPTH = 64;
  localparam int HIST_IDX_W    = $clog2(HISTORY_DEPTH);
  localparam int NUM_COEFS     = 6;
  localparam int WIN_MIN       = 2;
  localparam int WIN_MAX       = 60;
  localparam int WIN_CAP       = (HISTORY_DEPTH - 3 < WIN_MAX) ? HISTORY_DEPTH - 3 : WIN_MAX;
  localparam int SAMPLE_W      = 16;
  localparam int COEF_W        = 32;
  localparam int PROD_W        = SAMPLE_W + COEF_W;
  localparam int ACC_W         = 64;
  localparam int EST_W         = 48;
  localparam int WIN_W         = 6;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic        [ACC_W-1:0]    acc_t;
  typedef logic signed [EST_W-1:0]    est_t;
  typedef logic        [WIN_W-1:0]    win_t;
  typedef logic [HIST_IDX_W-1:0]      hist_idx_t;

  localparam est_t EST_MAX = {1'b0, {(EST_W-1){1'b1}}};
  localparam est_t EST_MIN = {1'b1, {(EST_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_LAG0     = 3'd0,
    REG_COEF_LAG1     = 3'd1,
    REG_COEF_LAG2     = 3'd2,
    REG_COEF_FAR1     = 3'd3,
    REG_COEF_FAR2     = 3'd4,
    REG_COEF_FAR3     = 3'd5,
    REG_WINDOW_LENGTH = 3'd6
  } cfg_reg_e;

  // per-cell select for the three far taps
  typedef struct packed {
    logic far1;
    logic far2;
    logic far3;
  } tap_sel_t;

  typedef struct packed {
    sample_t far1;
    sample_t far2;
    sample_t far3;
  } far_taps_t;

endpackage

@@ design/qwf_if.sv @@
interface qwf_in_if;
  import qwf_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface qwf_out_if;
  import qwf_pkg::*;
  logic valid;
  logic ready;
  est_t estimate;
  logic saturated;
  modport source (output valid, output estimate, output saturated, input ready);
  modport sink   (input valid, input estimate, input saturated, output ready);
endinterface

interface qwf_cfg_if;
  import qwf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/quadratic_window_fit_filter_top.sv @@
// Recursive quadratic smoother: takes one signed 16-bit sample per beat and returns one
// 48-bit saturated Q24.24 estimate per beat, in order. It accepts a sample every cycle
// while the result side keeps up; each sample passes the product registers, tap sum,
// recursion and saturation/output register in turn. The rate is set by the third-order
// recursion, which closes over the three stored 64-bit sums. Sample history is a row
// of shift cells; the far taps are picked by window_length. A stall on the result side
// holds the whole pipeline. Registers are written through the config channel, which is
// always ready; write them only while no sample is in flight.
module quadratic_window_fit_filter_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  qwf_in_if.sink     in_ch,
  qwf_out_if.source  out_ch,
  qwf_cfg_if.sink    cfg_ch
);
  import qwf_pkg::*;

  coef_t [NUM_COEFS-1:0] coef_q;
  win_t                  window_q;
  hist_idx_t             n_idx, n1_idx, n2_idx;
  logic                  adv;
  logic                  fire;
  sample_t               cell_in  [HISTORY_DEPTH];
  sample_t               cell_out [HISTORY_DEPTH];
  tap_sel_t              cell_sel [HISTORY_DEPTH];
  far_taps_t             cell_taps [HISTORY_DEPTH];
  far_taps_t             far;
  logic                  sum_valid;
  acc_t                  sum;
  logic                  out_valid;

  // config registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q   <= '0;
      window_q <= win_t'(WIN_MIN);
    end else if (cfg_ch.valid) begin
      case (cfg_reg_e'(cfg_ch.index))
        REG_COEF_LAG0:     coef_q[0] <= coef_t'(cfg_ch.data);
        REG_COEF_LAG1:     coef_q[1] <= coef_t'(cfg_ch.data);
        REG_COEF_LAG2:     coef_q[2] <= coef_t'(cfg_ch.data);
        REG_COEF_FAR1:     coef_q[3] <= coef_t'(cfg_ch.data);
        REG_COEF_FAR2:     coef_q[4] <= coef_t'(cfg_ch.data);
        REG_COEF_FAR3:     coef_q[5] <= coef_t'(cfg_ch.data);
        REG_WINDOW_LENGTH: window_q  <= cfg_ch.data[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp window into the range the history can serve
  always_comb begin
    if (int'(window_q) < WIN_MIN) begin
      n_idx = hist_idx_t'(WIN_MIN);
    end else if (int'(window_q) > WIN_CAP) begin
      n_idx = hist_idx_t'(WIN_CAP);
    end else begin
      n_idx = hist_idx_t'(window_q);
    end
    n1_idx = n_idx + hist_idx_t'(1);
    n2_idx = n_idx + hist_idx_t'(2);
  end

  // whole pipeline moves together; output register frees when taken
  assign adv          = !out_valid || out_ch.ready;
  assign fire         = in_ch.valid && adv;
  assign in_ch.ready  = adv;

  for (genvar k = 0; k < HISTORY_DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign cell_in[k] = in_ch.sample;
    end else begin : g_body
      assign cell_in[k] = cell_out[k-1];
    end
    assign cell_sel[k].far1 = (n_idx  == hist_idx_t'(k));
    assign cell_sel[k].far2 = (n1_idx == hist_idx_t'(k));
    assign cell_sel[k].far3 = (n2_idx == hist_idx_t'(k));

    qwf_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_en_i (fire),
      .sample_i   (cell_in[k]),
      .sel_i      (cell_sel[k]),
      .sample_o   (cell_out[k]),
      .taps_o     (cell_taps[k])
    );
  end

  // selected cells drive, the rest contribute zero
  always_comb begin
    far = '0;
    for (int k = 0; k < HISTORY_DEPTH; k++) begin
      far = far | cell_taps[k];
    end
  end

  qwf_tap_mac u_tap_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .fire_i      (fire),
    .x0_i        (in_ch.sample),
    .lag1_i      (cell_out[0]),
    .lag2_i      (cell_out[1]),
    .far_i       (far),
    .coef_i      (coef_q),
    .sum_valid_o (sum_valid),
    .sum_o       (sum)
  );

  qwf_recursion u_recursion (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .sum_valid_i (sum_valid),
    .sum_i       (sum),
    .out_valid_o (out_valid),
    .estimate_o  (out_ch.estimate),
    .saturated_o (out_ch.saturated)
  );

  assign out_ch.valid = out_valid;

endmodule

@@ design/qwf_cell.sv @@
module qwf_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                shift_en_i,
  input  qwf_pkg::sample_t    sample_i,
  input  qwf_pkg::tap_sel_t   sel_i,
  output qwf_pkg::sample_t    sample_o,
  output qwf_pkg::far_taps_t  taps_o
);
  import qwf_pkg::*;

  sample_t sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else if (shift_en_i) begin
      sample_q <= sample_i;
    end
  end

  assign sample_o    = sample_q;
  assign taps_o.far1 = sel_i.far1 ? sample_q : '0;
  assign taps_o.far2 = sel_i.far2 ? sample_q : '0;
  assign taps_o.far3 = sel_i.far3 ? sample_q : '0;

endmodule

@@ design/qwf_tap_mac.sv @@
module qwf_tap_mac (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       adv_i,
  input  logic                                       fire_i,
  input  qwf_pkg::sample_t                           x0_i,
  input  qwf_pkg::sample_t                           lag1_i,
  input  qwf_pkg::sample_t                           lag2_i,
  input  qwf_pkg::far_taps_t                         far_i,
  input  qwf_pkg::coef_t [qwf_pkg::NUM_COEFS-1:0]    coef_i,
  output logic                                       sum_valid_o,
  output qwf_pkg::acc_t                              sum_o
);
  import qwf_pkg::*;

  sample_t x [NUM_COEFS];
  prod_t   prod_d [NUM_COEFS];
  prod_t   prod_q [NUM_COEFS];
  logic    prod_valid_q;
  acc_t    sum_d;
  acc_t    sum_q;
  logic    sum_valid_q;

  always_comb begin
    x[0] = x0_i;
    x[1] = lag1_i;
    x[2] = lag2_i;
    x[3] = far_i.far1;
    x[4] = far_i.far2;
    x[5] = far_i.far3;
    for (int i = 0; i < NUM_COEFS; i++) begin
      prod_d[i] = prod_t'(coef_i[i]) * prod_t'(x[i]);
    end
  end

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < NUM_COEFS; i++) begin
      sum_d = sum_d + acc_t'(prod_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      sum_valid_q  <= 1'b0;
    end else if (adv_i) begin
      prod_valid_q <= fire_i;
      sum_valid_q  <= prod_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && fire_i) begin
      for (int i = 0; i < NUM_COEFS; i++) begin
        prod_q[i] <= prod_d[i];
      end
    end
    if (adv_i && prod_valid_q) begin
      sum_q <= sum_d;
    end
  end

  assign sum_valid_o = sum_valid_q;
  assign sum_o       = sum_q;

endmodule

@@ design/qwf_recursion.sv @@
module qwf_recursion (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic           sum_valid_i,
  input  qwf_pkg::acc_t  sum_i,
  output logic           out_valid_o,
  output qwf_pkg::est_t  estimate_o,
  output logic           saturated_o
);
  import qwf_pkg::*;

  acc_t y1_q, y2_q, y3_q;
  acc_t y_d;
  logic y_valid_q;
  logic out_valid_q;
  est_t est_d, est_q;
  logic sat_d, sat_q;
  logic [ACC_W-EST_W:0] top_bits;

  // wraps modulo 2^64 like the stored sums
  assign y_d = (y1_q << 1) + y1_q - ((y2_q << 1) + y2_q) + y3_q + sum_i;

  assign top_bits = y1_q[ACC_W-1:EST_W-1];

  always_comb begin
    est_d = est_t'(y1_q[EST_W-1:0]);
    sat_d = 1'b0;
    if (!((&top_bits) || !(|top_bits))) begin
      sat_d = 1'b1;
      est_d = y1_q[ACC_W-1] ? EST_MIN : EST_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y1_q        <= '0;
      y2_q        <= '0;
      y3_q        <= '0;
      y_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      y_valid_q   <= sum_valid_i;
      out_valid_q <= y_valid_q;
      if (sum_valid_i) begin
        y1_q <= y_d;
        y2_q <= y1_q;
        y3_q <= y2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && y_valid_q) begin
      est_q <= est_d;
      sat_q <= sat_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign estimate_o  = est_q;
  assign saturated_o = sat_q;

endmodule

@@ design/qwf_checker.sv @@
module qwf_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_ready_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input qwf_pkg::est_t   estimate_i,
  input logic            saturated_i
);
  import qwf_pkg::*;

  // stalled result beat stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(estimate_i) && $stable(saturated_i))
    else $error("result payload changed while stalled");

  // clipped estimates sit at one of the two rails
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && saturated_i |-> estimate_i == EST_MAX || estimate_i == EST_MIN)
    else $error("saturated estimate not at a rail");

  // input side only waits on a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i || out_ready_i |-> in_ready_i)
    else $error("input stalled without a held result");

endmodule

bind quadratic_window_fit_filter_top qwf_checker u_qwf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .estimate_i  (out_ch.estimate),
  .saturated_i (out_ch.saturated)
);

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import qwf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
  localparam sample_t SAMPLE_MAX      = 16'sh7fff;
  localparam sample_t SAMPLE_MIN      = -16'sh8000;
  localparam int      DRAIN_CYCLES    = 8;
  localparam int      HOLD_OFF_CYCLES = 200;
  localparam int      STABLE_ITEMS    = 650;
  localparam int      TOTAL_ITEMS     = 1000;
  localparam int      NUM_ROWS        = 56;

  typedef enum {ROW_WRITE, ROW_SAMPLE, ROW_FLUSH} row_kind_e;

  typedef struct {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic signed [31:0]     data;
    bit                     pinned;
    est_t                   est;
    bit                     sat;
  } dir_row_t;

  typedef struct {
    est_t estimate;
    logic saturated;
  } est_beat_t;

  logic clk_i;
  logic rst_ni;

  qwf_in_if  in_ch();
  qwf_out_if out_ch();
  qwf_cfg_if cfg_ch();

  quadratic_window_fit_filter_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // own copy of the smoother state
  coef_t   fit_coef [NUM_COEFS];
  win_t    fit_win;
  sample_t hist [HISTORY_DEPTH];
  acc_t    past_sum [3];

  est_beat_t pending_estimates [$];
  est_beat_t want;
  int        mismatch_count = 0;
  bit        no_idle = 1'b0;
  bit        hold_off_req = 1'b0;

  // the later coefficient rows use a moving-sum shape a*(1,-2,1) and -a*(1,-2,1) on the far
  // taps, which cancels the triple integrator; history is flushed before each of those retunes
  dir_row_t directed_rows [NUM_ROWS] = '{
    '{ROW_SAMPLE, '0, 32767, 1'b1, '0, 1'b0},
    '{ROW_SAMPLE, '0, -32768, 1'b1, '0, 1'b0},
    '{ROW_WRITE, REG_COEF_LAG0, 32'h8000_0000, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, '0, 8192, 1'b1, -48'sd17592186044416, 1'b0},
    '{ROW_SAMPLE, '0, -24576, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, '0, 24576, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, '0, -8192, 1'b0, '0, 1'b0},
    '{ROW_WRITE, REG_COEF_LAG0, 32'h7fff_ffff, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, '0, -8192, 1'b1, -48'sd17592186036224, 1'b0},
    '{ROW_SAMPLE, '0, 24576, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, '0, -24576, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, '0, 8192, 1'b0, '0, 1'b0},
    '{ROW_FLUSH, '0, 0, 1'b0, '0, 1'b0},
    '{ROW_WRITE, REG_UNMAPPED, 32'hffff_ffff, 1'b0, '0, 1'b0},
    '{ROW_WRITE, REG_COEF_LAG0, 32'h0100_0000, 1'b0, '0, 1'b0},
    '{ROW_WRITE, REG_COEF_LAG1, 32'hfe00_0000, 1'b0, '0, 1'b0},
    '{ROW_WRITE, REG_COEF_LAG2, 32'h0100_0000, 1'b0, '0, 1'b0},
    '{ROW_WRITE, REG_COEF_FAR1, 32'hff00_0000, 1'b0, '0, 1'b0},
    '{ROW_WRITE, REG_COEF_FAR2, 32'h0200_0000, 1'b0, '0, 1'b0},
    '{ROW_WRITE, REG_COEF_FAR3, 32'hff00_0000, 1'b0, '0, 1'b0},
    '{ROW_WRITE, REG_WINDOW_LENGTH, 32'h0000_0000, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, '0, 100, 1'b1, 48'sd1677721600, 1'b0},
    '{ROW_SAMPLE, '0, 32767, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, '0, -32768, 1'b0, '0, 1'b0},
    '{ROW_FLUSH, '0, 0, 1'b0, '0, 1'b0},
    '{ROW_WRITE, REG_WINDOW_LENGTH, 32'hffff_ffc1, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, '0, -1234, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, '0, 4321, 1'b0, '0, 1'b0},
    '{ROW_FLUSH, '0, 0, 1'b0, '0, 1'b0},
    '{ROW_WRITE, REG_WINDOW_LENGTH, 32'h0000_003f, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, '0, 32767, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, '0, 32767, 1'b0, '0, 1'b0},
    '{ROW_FLUSH, '0, 0, 1'b0, '0, 1'b0},
    '{ROW_WRITE, REG_WINDOW_LENGTH, 32'h0000_003d, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, '0, -32768, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, '0, 1, 1'b0, '0, 1'b0},
    '{ROW_FLUSH, '0, 0, 1'b0, '0, 1'b0},
    '{ROW_WRITE, REG_WINDOW_LENGTH, 32'h0000_003c, 1'b0, '0, 1'b0},
    '{ROW_WRITE, REG_COEF_LAG0, 32'h3fff_ffff, 1'b0, '0, 1'b0},
    '{ROW_WRITE, REG_COEF_LAG1, 32'h8000_0002, 1'b0, '0, 1'b0},
    '{ROW_WRITE, REG_COEF_LAG2, 32'h3fff_ffff, 1'b0, '0, 1'b0},
    '{ROW_WRITE, REG_COEF_FAR1, 32'hc000_0001, 1'b0, '0, 1'b0},
    '{ROW_WRITE, REG_COEF_FAR2, 32'h7fff_fffe, 1'b0, '0, 1'b0},
    '{ROW_WRITE, REG_COEF_FAR3, 32'hc000_0001, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, '0, 32767, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, '0, 32767, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, '0, 32767, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, '0, 32767, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, '0, 32767, 1'b1, EST_MAX, 1'b1},
    '{ROW_FLUSH, '0, 0, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, '0, -32768, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, '0, -32768, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, '0, -32768, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, '0, -32768, 1'b0, '0, 1'b0},
    '{ROW_SAMPLE, '0, -32768, 1'b1, EST_MIN, 1'b1},
    '{ROW_FLUSH, '0, 0, 1'b0, '0, 1'b0}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic acc_t weigh(coef_t c, sample_t x);
    return acc_t'(longint'(c) * longint'(x));
  endfunction

  function automatic void apply_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    if (idx < NUM_COEFS) begin
      fit_coef[idx] = coef_t'(data);
    end else if (idx == REG_WINDOW_LENGTH) begin
      fit_win = data[WIN_W-1:0];
    end
  endfunction

  function automatic est_beat_t smooth_step(sample_t x);
    int        n;
    acc_t      acc;
    longint    s_acc;
    est_beat_t r;
    n = fit_win;
    if (n < WIN_MIN) n = WIN_MIN;
    if (n > WIN_CAP) n = WIN_CAP;
    acc = acc_t'(3) * past_sum[0] - acc_t'(3) * past_sum[1] + past_sum[2];
    acc += weigh(fit_coef[0], x);
    acc += weigh(fit_coef[1], hist[0]);
    acc += weigh(fit_coef[2], hist[1]);
    acc += weigh(fit_coef[3], hist[n]);
    acc += weigh(fit_coef[4], hist[n+1]);
    acc += weigh(fit_coef[5], hist[n+2]);
    for (int i = HISTORY_DEPTH - 1; i > 0; i--) hist[i] = hist[i-1];
    hist[0] = x;
    past_sum[2] = past_sum[1];
    past_sum[1] = past_sum[0];
    past_sum[0] = acc;
    // stored sum keeps wrapping, only the reported value clips
    s_acc = longint'(acc);
    if (s_acc > longint'(EST_MAX)) begin
      r.estimate = EST_MAX;
      r.saturated = 1'b1;
    end else if (s_acc < longint'(EST_MIN)) begin
      r.estimate = EST_MIN;
      r.saturated = 1'b1;
    end else begin
      r.estimate = est_t'(acc[EST_W-1:0]);
      r.saturated = 1'b0;
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic sample_t rand_sample(int style);
    case (style)
      0: return sample_t'($urandom);
      1: return sample_t'($urandom_range(0, 600) - 300);
      2: return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
      default: return rand_sample($urandom_range(0, 2));
    endcase
  endfunction

  // moving-sum scale; |a| stays below 2^30 so -2a still fits the register
  function automatic coef_t pick_scale();
    case ($urandom_range(0, 4))
      0: return coef_t'(32'h3fff_ffff);
      1: return coef_t'(32'hc000_0001);
      2: return coef_t'($urandom_range(0, 32'h7fff_fffe) - 32'h3fff_ffff);
      default: return coef_t'($urandom_range(0, 32'h0200_0000) - 32'h0100_0000);
    endcase
  endfunction

  function automatic logic [31:0] pick_window();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 11))
      0: w[WIN_W-1:0] = 6'd0;
      1: w[WIN_W-1:0] = 6'd1;
      2: w[WIN_W-1:0] = 6'd2;
      3: w[WIN_W-1:0] = 6'd3;
      4: w[WIN_W-1:0] = 6'd59;
      5: w[WIN_W-1:0] = 6'd60;
      6: w[WIN_W-1:0] = 6'd61;
      7: w[WIN_W-1:0] = 6'd63;
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 4))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic flag_mismatch(string what);
    mismatch_count++;
    $display("%0t mismatch: %s", $realtime, what);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    wait_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    apply_write(idx, data);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_sample(sample_t s, bit pinned = 1'b0, est_t pinned_est = '0,
                             bit pinned_sat = 1'b0);
    int        gap;
    est_beat_t beat;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    beat = smooth_step(s);
    if (pinned) begin
      beat.estimate  = pinned_est;
      beat.saturated = pinned_sat;
    end
    pending_estimates.push_back(beat);
  endtask

  // zeros wash the moving sum, the three past sums and the history back to zero
  task automatic flush_history();
    repeat (HISTORY_DEPTH) send_sample('0);
  endtask

  task automatic program_moving_sum(coef_t a, logic [31:0] win_data);
    write_reg(REG_COEF_LAG0, a);
    write_reg(REG_COEF_LAG1, coef_t'(-2 * a));
    write_reg(REG_COEF_LAG2, a);
    write_reg(REG_COEF_FAR1, coef_t'(-a));
    write_reg(REG_COEF_FAR2, coef_t'(2 * a));
    write_reg(REG_COEF_FAR3, coef_t'(-a));
    write_reg(REG_WINDOW_LENGTH, win_data);
    if ($urandom_range(0, 3) == 0) write_reg(REG_UNMAPPED, $urandom);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_estimates.size() == 0) begin
        flag_mismatch($sformatf("estimate beat %0d with nothing pending",
                                out_ch.estimate));
      end else begin
        want = pending_estimates.pop_front();
        if (out_ch.estimate !== want.estimate)
          flag_mismatch($sformatf("estimate %0d, want %0d", out_ch.estimate,
                                  want.estimate));
        if (out_ch.saturated !== want.saturated)
          flag_mismatch($sformatf("saturated %0b, want %0b", out_ch.saturated,
                                  want.saturated));
      end
    end
  end

  initial begin : result_pacing
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        // long hold so the pipeline fills and backs up into the input
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else if (no_idle) begin
        out_ch.ready <= 1'b1;
        @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
        stall = pick_gap();
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int          random_items;
    int          phase;
    int          style;
    int          len;
    logic [31:0] win_data;
    rst_ni        <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.sample  <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= '0;
    cfg_ch.data   <= '0;
    foreach (fit_coef[i]) fit_coef[i] = '0;
    foreach (hist[i]) hist[i] = '0;
    foreach (past_sum[i]) past_sum[i] = '0;
    fit_win = win_t'(WIN_MIN);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_WRITE:  write_reg(directed_rows[i].idx, directed_rows[i].data);
        ROW_SAMPLE: send_sample(sample_t'(directed_rows[i].data), directed_rows[i].pinned,
                                directed_rows[i].est, directed_rows[i].sat);
        ROW_FLUSH:  flush_history();
        default: ;
      endcase
    end

    // well-formed moving-sum setups, each started from clean state
    random_items = 0;
    phase = 0;
    while (random_items < STABLE_ITEMS) begin
      win_data = pick_window();
      program_moving_sum(pick_scale(), win_data);
      no_idle = (phase % 5 == 4) || (phase == 3);
      if (phase == 3 || phase == 9) hold_off_req = 1'b1;
      style = $urandom_range(0, 3);
      len = $urandom_range(16, 120);
      repeat (len) begin
        send_sample(rand_sample(style));
        if (!no_idle && $urandom_range(0, 59) == 0) wait_idle();
      end
      flush_history();
      random_items += len + HISTORY_DEPTH;
      no_idle = 1'b0;
      phase++;
    end

    // broken and arbitrary coefficient sets; the state drifts from here on
    while (random_items < TOTAL_ITEMS) begin
      if ($urandom_range(0, 1) == 1) begin
        program_moving_sum(pick_scale(), pick_window());
        write_reg(cfg_reg_e'($urandom_range(0, NUM_COEFS - 1)), rand_coef());
      end else begin
        write_reg(REG_COEF_LAG0, rand_coef());
        write_reg(REG_COEF_LAG1, rand_coef());
        write_reg(REG_COEF_LAG2, rand_coef());
        write_reg(REG_COEF_FAR1, rand_coef());
        write_reg(REG_COEF_FAR2, rand_coef());
        write_reg(REG_COEF_FAR3, rand_coef());
        write_reg(REG_WINDOW_LENGTH, $urandom);
      end
      style = $urandom_range(0, 3);
      len = $urandom_range(30, 120);
      repeat (len) send_sample(rand_sample(style));
      random_items += len;
    end

    wait_idle();
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0 && pending_estimates.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
